// ===== rtl/rtet_pkg.sv =====
// ----------------------------------------------------------------------------
// rtet_pkg
// Types and codes shared by the repeating timer event table.
// ----------------------------------------------------------------------------
package rtet_pkg;

	localparam logic [31:0] REPEAT_FOREVER = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_KILL = 2'd1,
		CMD_POLL = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		RES_ADDED     = 3'd0,
		RES_FULL      = 3'd1,
		RES_KILLED    = 3'd2,
		RES_NOT_FOUND = 3'd3,
		RES_FIRED     = 3'd4,
		RES_DONE      = 3'd5
	} result_kind_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] now_time;
		logic [31:0] period_ticks;
		logic [31:0] repeat_total;
		logic [7:0]  handler_tag;
		logic [31:0] target_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [31:0] event_ident;
		logic [7:0]  fired_tag;
		logic        last_of_run;
		logic [4:0]  active_count;
	} out_item_t;

endpackage

// ===== rtl/repeating_timer_event_table_top.sv =====
// ----------------------------------------------------------------------------
// repeating_timer_event_table_top
// Table of repeating timer slots with add, kill and poll commands.
// ----------------------------------------------------------------------------
// channel   handshake        payload
// command   push / full      cmd_item (in_item_t)
// result    pop / empty      result   (out_item_t)
//
// Add: the ADD state loads the result after the command is taken. Kill: the
// sequencer walks the age list until the id matches, or reports not found.
// Poll: the sequencer reads one slot a cycle while the result register can
// take a result; fired results come out along the way, then the done result.
// An unpopped result in the result register stalls the sequencer.
// Reset empties the table and sets the next id to one.
// A two-entry command queue lets commands arrive while the sequencer stalls
// on a full result register.
module repeating_timer_event_table_top
	import rtet_pkg::*;
#(
	parameter int SLOT_COUNT = 16,
	parameter int TAG_BITS   = 8
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  cmd_item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic     q_valid;
	logic     q_take;
	in_item_t q_item;

	rtet_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd_item (cmd_item),
		.q_valid  (q_valid),
		.q_take   (q_take),
		.q_item   (q_item)
	);

	rtet_back #(
		.SLOT_COUNT (SLOT_COUNT),
		.TAG_BITS   (TAG_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_take  (q_take),
		.q_item  (q_item),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== rtl/rtet_front.sv =====
// ----------------------------------------------------------------------------
// rtet_front
// Accepts command items, drops unknown commands and queues the rest.
// ----------------------------------------------------------------------------
module rtet_front
	import rtet_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t cmd_item,
	output logic     q_valid,
	input  logic     q_take,
	output in_item_t q_item
);

	in_item_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       store;
	logic       take;

	assign full    = cnt_q == 2'd2;
	assign store   = push && !full && (cmd_item.cmd != CMD_NONE);
	assign q_valid = cnt_q != 2'd0;
	assign take    = q_take && q_valid;
	assign q_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (store) begin
			mem_q[wr_q] <= cmd_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (store) begin
				wr_q <= !wr_q;
			end
			if (take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, store} - {1'b0, take};
		end
	end

endmodule

// ===== rtl/rtet_back.sv =====
// ----------------------------------------------------------------------------
// rtet_back
// Slot table and sequencer: runs add, kill and poll one slot per cycle while the result register can take a result.
// ----------------------------------------------------------------------------
module rtet_back
	import rtet_pkg::*;
#(
	parameter int SLOT_COUNT = 16,
	parameter int TAG_BITS   = 8
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_take,
	input  in_item_t  q_item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int TW = (TAG_BITS < 8) ? TAG_BITS : 8;

	typedef enum logic [1:0] {ST_IDLE, ST_ADD, ST_KILL, ST_POLL} state_t;

	state_t              state_q;
	in_item_t            cur_q;
	logic                used_q [SLOT_COUNT];
	logic [31:0]         ident_q [SLOT_COUNT];
	logic [31:0]         due_q [SLOT_COUNT];
	logic [31:0]         period_q [SLOT_COUNT];
	logic [31:0]         rem_q [SLOT_COUNT];
	logic [TW-1:0]       tag_q [SLOT_COUNT];
	logic [IW-1:0]       age_q [SLOT_COUNT];
	logic [CW-1:0]       active_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       left_q;
	logic [31:0]         next_id_q;
	out_item_t           out_q;
	logic                out_valid_q;

	logic                go;
	logic                out_load;
	logic [IW-1:0]       s;
	logic [IW-1:0]       free_s;
	logic                have_free;
	logic                hit;
	logic                due;
	logic                forever_rep;
	logic [31:0]         rem_dec;
	logic                fire_free;
	logic [31:0]         next_id_inc;
	logic [IW-1:0]       age_rm [SLOT_COUNT];
	logic [IW-1:0]       age_in [SLOT_COUNT];
	logic                add_we;
	logic                fire_we;
	logic [CW-1:0]       active_dn;
	logic [CW-1:0]       active_up;

	assign go          = !out_valid_q || pop;
	assign empty       = !out_valid_q;
	assign result      = out_q;
	assign q_take      = (state_q == ST_IDLE) && q_valid;
	assign s           = age_q[ptr_q[IW-1:0]];
	assign hit         = ident_q[s] == cur_q.target_id;
	assign due         = cur_q.now_time >= due_q[s];
	assign forever_rep = rem_q[s] == REPEAT_FOREVER;
	assign rem_dec     = rem_q[s] - 32'd1;
	assign fire_free   = !forever_rep && (rem_dec == 32'd0);
	assign next_id_inc = next_id_q + 32'd1;
	assign active_dn   = active_q - CW'(1);
	assign active_up   = active_q + CW'(1);
	assign add_we      = (state_q == ST_ADD) && go && have_free;
	assign fire_we     = (state_q == ST_POLL) && go && (left_q != '0) && due;
	// a new item enters the result register this cycle
	assign out_load    = go && ((state_q == ST_ADD) ||
		((state_q == ST_KILL) && ((ptr_q == active_q) || hit)) ||
		((state_q == ST_POLL) && ((left_q == '0) || due)));

	// lowest free slot
	always_comb begin
		have_free = 1'b0;
		free_s    = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				have_free = 1'b1;
				free_s    = IW'(i);
			end
		end
	end

	// age list with the entry at ptr removed, and with a new head inserted
	always_comb begin
		for (int j = 0; j < SLOT_COUNT; j++) begin
			if (j < SLOT_COUNT - 1 && CW'(j) >= ptr_q) begin
				age_rm[j] = age_q[j + 1];
			end else begin
				age_rm[j] = age_q[j];
			end
			if (j == 0) begin
				age_in[j] = free_s;
			end else begin
				age_in[j] = age_q[j - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_we) begin
			ident_q[free_s]  <= next_id_q;
			due_q[free_s]    <= cur_q.now_time + cur_q.period_ticks;
			period_q[free_s] <= cur_q.period_ticks;
			rem_q[free_s]    <= cur_q.repeat_total;
			tag_q[free_s]    <= cur_q.handler_tag[TW-1:0];
		end
		if (fire_we) begin
			due_q[s] <= cur_q.now_time + period_q[s];
			if (!forever_rep) begin
				rem_q[s] <= rem_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			active_q    <= '0;
			ptr_q       <= '0;
			left_q      <= '0;
			next_id_q   <= 32'd1;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				used_q[i] <= 1'b0;
				age_q[i]  <= '0;
			end
		end else begin
			if (pop && out_valid_q && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cur_q  <= q_item;
						ptr_q  <= '0;
						left_q <= active_q;
						case (q_item.cmd)
							CMD_ADD:  state_q <= ST_ADD;
							CMD_KILL: state_q <= ST_KILL;
							CMD_POLL: state_q <= ST_POLL;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD: begin
					if (go) begin
						out_valid_q       <= 1'b1;
						out_q.fired_tag   <= '0;
						out_q.last_of_run <= 1'b1;
						state_q           <= ST_IDLE;
						if (have_free) begin
							used_q[free_s]     <= 1'b1;
							age_q              <= age_in;
							active_q           <= active_up;
							next_id_q          <= (next_id_inc == 32'd0) ? 32'd1 : next_id_inc;
							out_q.result_kind  <= RES_ADDED;
							out_q.event_ident  <= next_id_q;
							out_q.active_count <= 5'(active_up);
						end else begin
							out_q.result_kind  <= RES_FULL;
							out_q.event_ident  <= '0;
							out_q.active_count <= 5'(active_q);
						end
					end
				end
				ST_KILL: begin
					if (go) begin
						if (ptr_q == active_q) begin
							out_valid_q        <= 1'b1;
							out_q.result_kind  <= RES_NOT_FOUND;
							out_q.event_ident  <= '0;
							out_q.fired_tag    <= '0;
							out_q.last_of_run  <= 1'b1;
							out_q.active_count <= 5'(active_q);
							state_q            <= ST_IDLE;
						end else if (hit) begin
							used_q[s]          <= 1'b0;
							age_q              <= age_rm;
							active_q           <= active_dn;
							out_valid_q        <= 1'b1;
							out_q.result_kind  <= RES_KILLED;
							out_q.event_ident  <= cur_q.target_id;
							out_q.fired_tag    <= '0;
							out_q.last_of_run  <= 1'b1;
							out_q.active_count <= 5'(active_dn);
							state_q            <= ST_IDLE;
						end else begin
							ptr_q <= ptr_q + CW'(1);
						end
					end
				end
				ST_POLL: begin
					if (go) begin
						if (left_q == '0) begin
							out_valid_q        <= 1'b1;
							out_q.result_kind  <= RES_DONE;
							out_q.event_ident  <= '0;
							out_q.fired_tag    <= '0;
							out_q.last_of_run  <= 1'b1;
							out_q.active_count <= 5'(active_q);
							state_q            <= ST_IDLE;
						end else begin
							left_q <= left_q - CW'(1);
							if (due) begin
								out_valid_q       <= 1'b1;
								out_q.result_kind <= RES_FIRED;
								out_q.event_ident <= ident_q[s];
								out_q.fired_tag   <= 8'(tag_q[s]);
								out_q.last_of_run <= 1'b0;
								// a freed slot closes up the list: hold the pointer
								if (fire_free) begin
									used_q[s]          <= 1'b0;
									age_q              <= age_rm;
									active_q           <= active_dn;
									out_q.active_count <= 5'(active_dn);
								end else begin
									ptr_q              <= ptr_q + CW'(1);
									out_q.active_count <= 5'(active_q);
								end
							end else begin
								ptr_q <= ptr_q + CW'(1);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
